>>> rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// Sixteen-step sequencer package
// Shared constants, opcode and play mode codes, and the structs that pass
// configuration and per-request status between the sequencer modules.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Number of step slots. Random positions are taken by masking the LFSR, so this stays a power of two.
  localparam int NUM_STEPS      = 16;
  localparam int STEP_BITS      = $clog2(NUM_STEPS);
  localparam int LEVEL_BITS_DEF = 16;

  localparam logic [31:0] PERIOD_RESET = 32'd1536000;
  localparam logic [31:0] PHASE_INC    = 32'd256;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam logic [15:0] LFSR_POLY    = 16'hB400;

  localparam int CFG_IDX_BITS = 8;

  typedef enum logic [2:0] {
    OP_SAMPLE   = 3'd0,
    OP_EXT_TICK = 3'd1,
    OP_TRIGGER  = 3'd2,
    OP_WRITE    = 3'd3,
    OP_RESTART  = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_BACKWARD = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_RANDOM   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PERIOD  = 8'd0,
    CFG_MODE    = 8'd1,
    CFG_SOURCE  = 8'd2,
    CFG_ENABLED = 8'd3
  } cfg_idx_t;

  typedef logic [STEP_BITS-1:0] pos_t;

  typedef struct packed {
    logic [31:0] period;
    mode_t       mode;
    logic        ext_clock;
    logic        enabled;
  } cfg_t;

  // Status of one request on its way from the control stage to the result stage.
  typedef struct packed {
    logic adv;      // the step advanced; gate and level come from the table
    logic clr;      // gate and level are cleared
    logic rd;       // a valid read step; the table data is returned
    logic started;
    pos_t pos;
  } tag_t;

endpackage

>>> rtl/sss_ctrl.sv
// ----------------------------------------------------------------------------
// Sequencer control stage
// Holds position, direction, phase counter and LFSR, decodes each request and
// issues the step table read or write that it needs.
// ----------------------------------------------------------------------------
module sss_ctrl #(
  parameter int LEVEL_BITS = sss_pkg::LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sss_pkg::cfg_t         cfg,
  input  logic                  accept,
  input  logic [2:0]            opcode,
  input  logic [3:0]            step_index,
  input  logic                  step_active,
  input  logic [15:0]           step_value,
  output sss_pkg::tag_t         tag,
  output logic                  rd_en,
  output sss_pkg::pos_t         rd_addr,
  output logic                  wr_en,
  output sss_pkg::pos_t         wr_addr,
  output logic                  wr_active,
  output logic [LEVEL_BITS-1:0] wr_level
);
  import sss_pkg::*;

  localparam int SAT_W = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam logic [SAT_W-1:0] LVL_MAX = SAT_W'((64'd1 << LEVEL_BITS) - 64'd1);
  localparam pos_t POS_LAST = STEP_BITS'(NUM_STEPS - 1);

  pos_t        pos, pos_next, adv_pos;
  logic        started, started_next;
  logic        down, down_next, adv_down;
  logic [31:0] phase, phase_next;
  logic [15:0] lfsr, lfsr_next, lfsr_step;
  logic [32:0] sum, diff;
  logic [SAT_W-1:0] val_ext;
  logic        idx_ok, adv, clr, rd, rd_req, wr_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      started <= 1'b0;
      down    <= 1'b0;
      phase   <= '0;
      lfsr    <= LFSR_SEED;
    end else if (accept) begin
      pos     <= pos_next;
      started <= started_next;
      down    <= down_next;
      phase   <= phase_next;
      lfsr    <= lfsr_next;
    end
  end

  // Next position for one advance in the current play mode.
  always_comb begin
    lfsr_step = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_POLY : 16'h0000);
    adv_pos   = pos;
    adv_down  = down;
    if (!started) begin
      adv_pos  = (cfg.mode == MODE_BACKWARD) ? POS_LAST : '0;
      adv_down = 1'b0;
    end else begin
      case (cfg.mode)
        MODE_FORWARD:  adv_pos = (pos == POS_LAST) ? '0 : pos + 1'b1;
        MODE_BACKWARD: adv_pos = (pos == '0) ? POS_LAST : pos - 1'b1;
        MODE_PINGPONG: begin
          if (down) begin
            if (pos <= pos_t'(1)) begin
              adv_pos  = '0;
              adv_down = 1'b0;
            end else begin
              adv_pos = pos - 1'b1;
            end
          end else begin
            if ({1'b0, pos} + 1'b1 >= {1'b0, POS_LAST}) begin
              adv_pos  = POS_LAST;
              adv_down = 1'b1;
            end else begin
              adv_pos = pos + 1'b1;
            end
          end
        end
        MODE_RANDOM:   adv_pos = lfsr_step[STEP_BITS-1:0];
        default:       adv_pos = pos;
      endcase
    end
  end

  always_comb begin
    pos_next     = pos;
    started_next = started;
    down_next    = down;
    phase_next   = phase;
    lfsr_next    = lfsr;
    adv          = 1'b0;
    clr          = 1'b0;
    rd_req       = 1'b0;
    wr_req       = 1'b0;
    idx_ok       = int'(step_index) < NUM_STEPS;
    sum          = {1'b0, phase} + {1'b0, PHASE_INC};
    diff         = sum - {1'b0, cfg.period};
    val_ext      = SAT_W'(step_value);

    case (opcode)
      OP_SAMPLE: begin
        if (!cfg.enabled) begin
          clr = 1'b1;
        end else if (!cfg.ext_clock && cfg.period != '0) begin
          if (sum >= {1'b0, cfg.period}) begin
            adv        = 1'b1;
            phase_next = diff[32] ? 32'hFFFF_FFFF : diff[31:0];
          end else begin
            phase_next = sum[31:0];
          end
        end
      end
      OP_EXT_TICK: adv = cfg.enabled;
      OP_TRIGGER: begin
        pos_next     = '0;
        phase_next   = '0;
        down_next    = 1'b0;
        started_next = 1'b1;
      end
      OP_WRITE:   wr_req = idx_ok;
      OP_RESTART: begin
        pos_next     = '0;
        phase_next   = '0;
        down_next    = 1'b0;
        started_next = 1'b0;
        clr          = 1'b1;
      end
      OP_READ:    rd_req = idx_ok;
      default:    ;
    endcase

    if (adv) begin
      pos_next     = adv_pos;
      down_next    = adv_down;
      started_next = 1'b1;
      if (started && cfg.mode == MODE_RANDOM) begin
        lfsr_next = lfsr_step;
      end
    end

    rd    = rd_req;
    rd_en = accept & (adv | rd_req);
    rd_addr   = adv ? adv_pos : step_index[STEP_BITS-1:0];
    wr_en     = accept & wr_req;
    wr_addr   = step_index[STEP_BITS-1:0];
    wr_active = step_active;
    wr_level  = (val_ext > LVL_MAX) ? LEVEL_BITS'(LVL_MAX) : LEVEL_BITS'(val_ext);

    tag = '{adv: adv, clr: clr, rd: rd, started: started_next, pos: pos_next};
  end

endmodule

>>> rtl/sss_table.sv
// ----------------------------------------------------------------------------
// Step table
// Synchronous step memory with one write and one registered read port. An
// entry not yet written since reset reads as its ramp reset value.
// ----------------------------------------------------------------------------
module sss_table #(
  parameter int LEVEL_BITS = sss_pkg::LEVEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sss_pkg::pos_t         wr_addr,
  input  logic                  wr_active,
  input  logic [LEVEL_BITS-1:0] wr_level,
  input  logic                  rd_en,
  input  sss_pkg::pos_t         rd_addr,
  output logic                  rd_active,
  output logic [LEVEL_BITS-1:0] rd_level
);
  import sss_pkg::*;

  logic [LEVEL_BITS:0]   mem [NUM_STEPS];
  logic [NUM_STEPS-1:0]  written;
  logic [LEVEL_BITS-1:0] init_level [NUM_STEPS];
  logic [LEVEL_BITS:0]   rd_q;
  logic                  init_q;
  pos_t                  addr_q;

  // Reset ramp: slot i holds round(i * full scale / (NUM_STEPS - 1)).
  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_init
    localparam longint LMAX = (longint'(1) << LEVEL_BITS) - 1;
    localparam longint VAL  = (g * LMAX + (NUM_STEPS - 1) / 2) / (NUM_STEPS - 1);
    assign init_level[g] = LEVEL_BITS'(VAL);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_active, wr_level};
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      init_q <= !written[rd_addr];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_active = init_q ? 1'b1 : rd_q[LEVEL_BITS];
  assign rd_level  = init_q ? init_level[addr_q] : rd_q[LEVEL_BITS-1:0];

endmodule

>>> rtl/sixteen_step_sequencer.sv
// ----------------------------------------------------------------------------
// Sixteen-step sequencer
// Step sequencer with a sixteen-slot table of active bits and levels, an
// internal 24.8 phase counter or external ticks, and four play modes.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle, back to back, while out_ready holds; the
// control stage and the registered table read form a two-stage pipeline.
// Reset: synchronous, active high. Configuration, position, counter and LFSR
// return to their defaults at once; the step table needs no clearing pass,
// since per-slot written bits make untouched slots read as the reset ramp.
// ----------------------------------------------------------------------------
module sixteen_step_sequencer #(
  parameter int LEVEL_BITS = sss_pkg::LEVEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sss_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       opcode,
  input  logic [3:0]                       step_index,
  input  logic                             step_active,
  input  logic [15:0]                      step_value,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             gate,
  output logic [15:0]                      level,
  output logic [3:0]                       position,
  output logic                             has_started,
  output logic                             read_active,
  output logic [15:0]                      read_level
);
  import sss_pkg::*;

  cfg_t                  cfg;
  logic                  accept, out_take;
  tag_t                  tag, tag_q;
  logic                  rd_en, wr_en, wr_active;
  pos_t                  rd_addr, wr_addr;
  logic [LEVEL_BITS-1:0] wr_level, tbl_level;
  logic                  tbl_active;
  logic                  gate_reg;
  logic [LEVEL_BITS-1:0] level_reg;
  logic                  gate_now;
  logic [LEVEL_BITS-1:0] level_now;

  // Configuration registers. Writes to indexes past the list are accepted
  // and dropped. The port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period    <= PERIOD_RESET;
      cfg.mode      <= MODE_FORWARD;
      cfg.ext_clock <= 1'b0;
      cfg.enabled   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERIOD:  cfg.period    <= cfg_data;
        CFG_MODE:    cfg.mode      <= mode_t'(cfg_data[1:0]);
        CFG_SOURCE:  cfg.ext_clock <= cfg_data[0];
        CFG_ENABLED: cfg.enabled   <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // The result stage register doubles as the output register. A new request
  // enters whenever that stage is empty or its result leaves in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  sss_ctrl #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .opcode      (opcode),
    .step_index  (step_index),
    .step_active (step_active),
    .step_value  (step_value),
    .tag         (tag),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_active   (wr_active),
    .wr_level    (wr_level)
  );

  sss_table #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_active (wr_active),
    .wr_level  (wr_level),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_active (tbl_active),
    .rd_level  (tbl_level)
  );

  // Result stage. The table read data is held while the result is stalled,
  // because the table is read only when a request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q <= tag;
    end
  end

  // Gate and level state follows the results in order: it is committed when
  // a result is delivered, and the next result builds on it.
  always_comb begin
    gate_now  = gate_reg;
    level_now = level_reg;
    if (tag_q.adv) begin
      gate_now  = tbl_active;
      level_now = tbl_active ? tbl_level : '0;
    end else if (tag_q.clr) begin
      gate_now  = 1'b0;
      level_now = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_reg  <= 1'b0;
      level_reg <= '0;
    end else if (out_take) begin
      gate_reg  <= gate_now;
      level_reg <= level_now;
    end
  end

  assign gate        = gate_now;
  assign level       = 16'(level_now);
  assign position    = 4'(tag_q.pos);
  assign has_started = tag_q.started;
  assign read_active = tag_q.rd ? tbl_active : 1'b0;
  assign read_level  = tag_q.rd ? 16'(tbl_level) : 16'h0000;

endmodule
